// File: hdl/huffman_code_table_builder_unit_assert.svh
// Assertion macros for the Huffman code table builder.
`ifndef HUFFMAN_CODE_TABLE_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_UNIT_ASSERT_SVH

// plain check, held off during reset
`define HCTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define HCTB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HCTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/hctb_pkg.sv
// Types and constants for the Huffman code table builder.
package hctb_pkg;

  localparam int unsigned ALPHABET_DEF     = 128;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF   = 32;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned OSYM_W   = 7;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BITS_W   = 32;
  localparam int unsigned DIST_W   = 8;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned DEPTH_W  = 8;

  typedef enum logic [1:0] {
    MODE_COUNT  = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ABSENT   = 2'd1,
    STAT_TOO_LONG = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

endpackage

// File: hdl/huffman_code_table_builder_unit.sv
// Huffman code table builder: symbol counting, tree build, code lookup.
//
// Accepts one item per transfer on the slave side; tuser carries the mode
// (count, build, lookup or none), tdata the symbol. A count steps through
// idle, counter read and counter write; a lookup steps through idle, table
// read, evaluate and emit, plus any output wait. A build is run by a small
// sequencer around one compare/add datapath and a set of single-write-port
// memories: a selection sort of the leaves scans all ALPHABET counters once
// per distinct symbol plus one extra scan; then come the merges, the tree
// walk over the inner nodes and the table fill, one symbol at a time. A
// build is dominated by the leaf sort through the single counter memory
// read port. Input is not ready while an item is in work. Build and lookup
// produce one result transfer on the master side (status in tuser), held
// in an output register so the next item can be taken while it waits.
// Counts saturate at 2^COUNT_BITS-1 and are flushed at once by the build
// through per-entry valid bits.
`include "huffman_code_table_builder_unit_assert.svh"

module huffman_code_table_builder_unit
  import hctb_pkg::*;
#(
  parameter int unsigned ALPHABET     = ALPHABET_DEF,
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [6:0] symbol_out, [12:7] code_length,
                                      // [44:13] code_bits, [52:45] distinct_symbols
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned NODES   = 2 * ALPHABET - 1;
  localparam int unsigned SYM_AW  = $clog2(ALPHABET);
  localparam int unsigned NODE_AW = $clog2(NODES);
  localparam int unsigned CNT_W   = $clog2(ALPHABET + 1);
  localparam int unsigned NEXT_W  = $clog2(NODES + 1);
  localparam int unsigned PATH_W  = MAX_CODE_LEN;
  localparam int unsigned KEY_W   = COUNT_BITS + SYM_AW;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_CNT_RD = 20'h00002,
    ST_CNT_WR = 20'h00004,
    ST_LK_RD  = 20'h00008,
    ST_LK_EV  = 20'h00010,
    ST_S_RD   = 20'h00020,
    ST_S_EV   = 20'h00040,
    ST_M_CHK  = 20'h00080,
    ST_M_RD   = 20'h00100,
    ST_M_PICK = 20'h00200,
    ST_M_WR   = 20'h00400,
    ST_T_INIT = 20'h00800,
    ST_T_CHK  = 20'h01000,
    ST_T_RD   = 20'h02000,
    ST_T_WA   = 20'h04000,
    ST_T_WB   = 20'h08000,
    ST_F_CHK  = 20'h10000,
    ST_F_RD   = 20'h20000,
    ST_F_WR   = 20'h40000,
    ST_EMIT   = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // sequencer registers
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic [CNT_W-1:0]    idx_q, idx_d, p_q, p_d, n_q, n_d, li_q, li_d;
  logic [NEXT_W-1:0]   mi_q, mi_d, next_q, next_d, k_q, k_d;
  logic                first_q, first_d, found_q, found_d, phase_q, phase_d;
  logic                too_long_q, too_long_d, lk_hit_q, lk_hit_d;
  logic [KEY_W-1:0]    prev_q, prev_d, best_q, best_d;
  logic [NODE_AW-1:0]  a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [WEIGHT_W-1:0] a_w_q, a_w_d, b_w_q, b_w_d;

  // staged result
  logic [1:0]          res_stat_q, res_stat_d;
  logic [OSYM_W-1:0]   res_sym_q, res_sym_d;
  logic [LEN_W-1:0]    res_len_q, res_len_d;
  logic [BITS_W-1:0]   res_bits_q, res_bits_d;
  logic [DIST_W-1:0]   res_dist_q, res_dist_d;

  // output register
  logic                out_valid_q, out_load;
  logic [1:0]          out_stat_q;
  logic [OSYM_W-1:0]   out_sym_q;
  logic [LEN_W-1:0]    out_len_q;
  logic [BITS_W-1:0]   out_bits_q;
  logic [DIST_W-1:0]   out_dist_q;

  // symbol counters
  logic [COUNT_BITS-1:0] cnt_mem [ALPHABET];
  logic [ALPHABET-1:0]   cnt_vld_q;
  logic                  cnt_re, cnt_we, cnt_clr, cnt_hit_q;
  logic [SYM_AW-1:0]     cnt_addr;
  logic [COUNT_BITS-1:0] cnt_rd_q, cnt_wd, cnt_eff;

  // node weights, two read ports
  logic [WEIGHT_W-1:0] wt_mem [NODES];
  logic                wt_re, wt_we;
  logic [NODE_AW-1:0]  wt_wa, wt_ra_a, wt_ra_b;
  logic [WEIGHT_W-1:0] wt_wd, wt_a_rd_q, wt_b_rd_q;

  // node children {one, zero}
  logic [2*NODE_AW-1:0] ch_mem [NODES];
  logic                 ch_re, ch_we;
  logic [2*NODE_AW-1:0] ch_rd_q;

  // depth and path per node
  logic [DEPTH_W-1:0] dep_mem [NODES];
  logic [PATH_W-1:0]  path_mem [NODES];
  logic               dp_re, dp_we;
  logic [NODE_AW-1:0] dp_wa, dp_ra;
  logic [DEPTH_W-1:0] dep_wd, dep_rd_q;
  logic [PATH_W-1:0]  path_wd, path_rd_q;

  // leaves in sorted order
  logic [SYM_AW-1:0] pend_mem [ALPHABET];
  logic              pend_re, pend_we;
  logic [SYM_AW-1:0] pend_wd, pend_rd_q;

  // code table
  logic [DEPTH_W-1:0]  tbl_len_mem [ALPHABET];
  logic [PATH_W-1:0]   tbl_bits_mem [ALPHABET];
  logic                tbl_re, tbl_we;
  logic [DEPTH_W-1:0]  tbl_len_rd_q;
  logic [PATH_W-1:0]   tbl_bits_rd_q;
  logic [ALPHABET-1:0] code_vld_q;
  logic                code_clr, code_set;

  // shared datapath
  logic                sym_in_range;
  logic [KEY_W-1:0]    cur_key, best_sel;
  logic                cand, found_sel, take_leaf;
  logic [NEXT_W:0]     live;
  logic [WEIGHT_W:0]   wsum;
  logic [PATH_W+BITS_W-1:0] bits_ext;

  assign sym_in_range  = {1'b0, sym_q} < (SYM_W + 1)'(ALPHABET);
  assign cnt_eff       = cnt_hit_q ? cnt_rd_q : '0;
  assign cur_key       = {cnt_eff, idx_q[SYM_AW-1:0]};
  assign cand          = (cnt_eff != '0) && (first_q || (cur_key > prev_q)) &&
                         (!found_q || (cur_key < best_q));
  assign best_sel      = cand ? cur_key : best_q;
  assign found_sel     = found_q | cand;
  assign live          = (NEXT_W + 1)'(n_q) - (NEXT_W + 1)'(li_q) +
                         (NEXT_W + 1)'(next_q) - (NEXT_W + 1)'(mi_q);
  assign take_leaf     = (li_q < n_q) &&
                         ((mi_q >= next_q) || (wt_a_rd_q <= wt_b_rd_q));
  assign wsum          = {1'b0, a_w_q} + {1'b0, b_w_q};
  assign bits_ext      = {{BITS_W{1'b0}}, tbl_bits_rd_q};
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    idx_d      = idx_q;
    p_d        = p_q;
    n_d        = n_q;
    li_d       = li_q;
    mi_d       = mi_q;
    next_d     = next_q;
    k_d        = k_q;
    first_d    = first_q;
    found_d    = found_q;
    phase_d    = phase_q;
    too_long_d = too_long_q;
    lk_hit_d   = lk_hit_q;
    prev_d     = prev_q;
    best_d     = best_q;
    a_idx_d    = a_idx_q;
    a_w_d      = a_w_q;
    b_idx_d    = b_idx_q;
    b_w_d      = b_w_q;
    res_stat_d = res_stat_q;
    res_sym_d  = res_sym_q;
    res_len_d  = res_len_q;
    res_bits_d = res_bits_q;
    res_dist_d = res_dist_q;
    out_load   = 1'b0;
    cnt_re     = 1'b0;
    cnt_we     = 1'b0;
    cnt_clr    = 1'b0;
    cnt_addr   = idx_q[SYM_AW-1:0];
    cnt_wd     = cnt_eff + 1'b1;
    wt_re      = 1'b0;
    wt_we      = 1'b0;
    wt_wa      = next_q[NODE_AW-1:0];
    wt_wd      = wsum[WEIGHT_W] ? '1 : wsum[WEIGHT_W-1:0];
    wt_ra_a    = NODE_AW'(li_q);
    wt_ra_b    = mi_q[NODE_AW-1:0];
    ch_re      = 1'b0;
    ch_we      = 1'b0;
    dp_re      = 1'b0;
    dp_we      = 1'b0;
    dp_wa      = ch_rd_q[NODE_AW-1:0];
    dp_ra      = NODE_AW'(idx_q);
    dep_wd     = dep_rd_q + 1'b1;
    path_wd    = path_rd_q << 1;
    pend_re    = 1'b0;
    pend_we    = 1'b0;
    pend_wd    = best_sel[SYM_AW-1:0];
    tbl_re     = 1'b0;
    tbl_we     = 1'b0;
    code_clr   = 1'b0;
    code_set   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d = s_axis_tdata;
          unique case (mode_e'(s_axis_tuser))
            MODE_COUNT: begin
              if ({1'b0, s_axis_tdata} < (SYM_W + 1)'(ALPHABET)) begin
                state_d = ST_CNT_RD;
              end
            end
            MODE_BUILD: begin
              p_d        = '0;
              idx_d      = '0;
              first_d    = 1'b1;
              found_d    = 1'b0;
              too_long_d = 1'b0;
              code_clr   = 1'b1;
              state_d    = ST_S_RD;
            end
            MODE_LOOKUP: state_d = ST_LK_RD;
            MODE_NONE:   state_d = ST_IDLE;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD: begin
        cnt_re   = 1'b1;
        cnt_addr = sym_q[SYM_AW-1:0];
        state_d  = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cnt_addr = sym_q[SYM_AW-1:0];
        cnt_we   = (cnt_eff != '1);   // saturate
        state_d  = ST_IDLE;
      end
      ST_LK_RD: begin
        tbl_re   = 1'b1;
        lk_hit_d = sym_in_range && code_vld_q[sym_q[SYM_AW-1:0]];
        state_d  = ST_LK_EV;
      end
      ST_LK_EV: begin
        res_sym_d  = sym_q[OSYM_W-1:0];
        res_dist_d = '0;
        res_len_d  = '0;
        res_bits_d = '0;
        if (!lk_hit_q) begin
          res_stat_d = STAT_ABSENT;
        end else if (tbl_len_rd_q > DEPTH_W'(MAX_CODE_LEN)) begin
          res_stat_d = STAT_TOO_LONG;
        end else begin
          res_stat_d = STAT_OK;
          res_len_d  = tbl_len_rd_q[LEN_W-1:0];
          res_bits_d = bits_ext[BITS_W-1:0];
        end
        state_d = ST_EMIT;
      end
      // selection sort: each scan finds the next (count, symbol) key
      ST_S_RD: begin
        cnt_re  = 1'b1;
        state_d = ST_S_EV;
      end
      ST_S_EV: begin
        if (idx_q == CNT_W'(ALPHABET - 1)) begin
          idx_d   = '0;
          found_d = 1'b0;
          if (found_sel) begin
            pend_we = 1'b1;
            wt_we   = 1'b1;
            wt_wa   = NODE_AW'(p_q);
            wt_wd   = WEIGHT_W'(best_sel[KEY_W-1:SYM_AW]);
            prev_d  = best_sel;
            first_d = 1'b0;
            p_d     = p_q + 1'b1;
            state_d = ST_S_RD;
          end else begin
            n_d = p_q;
            if (p_q == '0) begin
              res_stat_d = STAT_EMPTY;
              res_sym_d  = '0;
              res_len_d  = '0;
              res_bits_d = '0;
              res_dist_d = '0;
              state_d    = ST_EMIT;
            end else begin
              li_d    = '0;
              mi_d    = NEXT_W'(p_q);
              next_d  = NEXT_W'(p_q);
              phase_d = 1'b0;
              state_d = ST_M_CHK;
            end
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          best_d  = best_sel;
          found_d = found_sel;
          state_d = ST_S_RD;
        end
      end
      // merge the two lightest of the leaf and inner queues
      ST_M_CHK: begin
        state_d = (live > (NEXT_W + 1)'(1)) ? ST_M_RD : ST_T_INIT;
      end
      ST_M_RD: begin
        wt_re   = 1'b1;
        state_d = ST_M_PICK;
      end
      ST_M_PICK: begin
        if (take_leaf) begin
          li_d = li_q + 1'b1;
        end else begin
          mi_d = mi_q + 1'b1;
        end
        if (!phase_q) begin
          a_idx_d = take_leaf ? NODE_AW'(li_q) : mi_q[NODE_AW-1:0];
          a_w_d   = take_leaf ? wt_a_rd_q : wt_b_rd_q;
          phase_d = 1'b1;
          state_d = ST_M_RD;
        end else begin
          b_idx_d = take_leaf ? NODE_AW'(li_q) : mi_q[NODE_AW-1:0];
          b_w_d   = take_leaf ? wt_a_rd_q : wt_b_rd_q;
          phase_d = 1'b0;
          state_d = ST_M_WR;
        end
      end
      ST_M_WR: begin
        wt_we   = 1'b1;
        ch_we   = 1'b1;
        next_d  = next_q + 1'b1;
        state_d = ST_M_CHK;
      end
      // walk inner nodes from the root down
      ST_T_INIT: begin
        dp_we   = 1'b1;
        dp_wa   = NODE_AW'(next_q - 1'b1);
        dep_wd  = '0;
        path_wd = '0;
        k_d     = next_q - 1'b1;
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        if (k_q >= NEXT_W'(n_q)) begin
          state_d = ST_T_RD;
        end else begin
          idx_d   = '0;
          state_d = ST_F_CHK;
        end
      end
      ST_T_RD: begin
        ch_re   = 1'b1;
        dp_re   = 1'b1;
        dp_ra   = k_q[NODE_AW-1:0];
        state_d = ST_T_WA;
      end
      ST_T_WA: begin
        dp_we   = 1'b1;
        state_d = ST_T_WB;
      end
      ST_T_WB: begin
        dp_we   = 1'b1;
        dp_wa   = ch_rd_q[2*NODE_AW-1:NODE_AW];
        path_wd = (path_rd_q << 1) | PATH_W'(1);
        k_d     = k_q - 1'b1;
        state_d = ST_T_CHK;
      end
      // copy leaf codes into the table
      ST_F_CHK: begin
        if (idx_q < n_q) begin
          state_d = ST_F_RD;
        end else begin
          cnt_clr    = 1'b1;
          res_stat_d = too_long_q ? STAT_TOO_LONG : STAT_OK;
          res_sym_d  = '0;
          res_len_d  = '0;
          res_bits_d = '0;
          res_dist_d = DIST_W'(n_q);
          state_d    = ST_EMIT;
        end
      end
      ST_F_RD: begin
        pend_re = 1'b1;
        dp_re   = 1'b1;
        state_d = ST_F_WR;
      end
      ST_F_WR: begin
        tbl_we   = 1'b1;
        code_set = 1'b1;
        if (dep_rd_q > DEPTH_W'(MAX_CODE_LEN)) begin
          too_long_d = 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ST_F_CHK;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
      code_vld_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cnt_clr) begin
        cnt_vld_q <= '0;
      end else if (cnt_we) begin
        cnt_vld_q[cnt_addr] <= 1'b1;
      end
      if (code_clr) begin
        code_vld_q <= '0;
      end else if (code_set) begin
        code_vld_q[pend_rd_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    idx_q      <= idx_d;
    p_q        <= p_d;
    n_q        <= n_d;
    li_q       <= li_d;
    mi_q       <= mi_d;
    next_q     <= next_d;
    k_q        <= k_d;
    first_q    <= first_d;
    found_q    <= found_d;
    phase_q    <= phase_d;
    too_long_q <= too_long_d;
    lk_hit_q   <= lk_hit_d;
    prev_q     <= prev_d;
    best_q     <= best_d;
    a_idx_q    <= a_idx_d;
    a_w_q      <= a_w_d;
    b_idx_q    <= b_idx_d;
    b_w_q      <= b_w_d;
    res_stat_q <= res_stat_d;
    res_sym_q  <= res_sym_d;
    res_len_q  <= res_len_d;
    res_bits_q <= res_bits_d;
    res_dist_q <= res_dist_d;
    if (out_load) begin
      out_stat_q <= res_stat_q;
      out_sym_q  <= res_sym_q;
      out_len_q  <= res_len_q;
      out_bits_q <= res_bits_q;
      out_dist_q <= res_dist_q;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_q  <= cnt_mem[cnt_addr];
      cnt_hit_q <= cnt_vld_q[cnt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
    if (wt_re) begin
      wt_a_rd_q <= wt_mem[wt_ra_a];
      wt_b_rd_q <= wt_mem[wt_ra_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_mem[next_q[NODE_AW-1:0]] <= {b_idx_q, a_idx_q};
    end
    if (ch_re) begin
      ch_rd_q <= ch_mem[k_q[NODE_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_we) begin
      dep_mem[dp_wa]  <= dep_wd;
      path_mem[dp_wa] <= path_wd;
    end
    if (dp_re) begin
      dep_rd_q  <= dep_mem[dp_ra];
      path_rd_q <= path_mem[dp_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[p_q[SYM_AW-1:0]] <= pend_wd;
    end
    if (pend_re) begin
      pend_rd_q <= pend_mem[idx_q[SYM_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_len_mem[pend_rd_q]  <= dep_rd_q;
      tbl_bits_mem[pend_rd_q] <= path_rd_q;
    end
    if (tbl_re) begin
      tbl_len_rd_q  <= tbl_len_mem[sym_q[SYM_AW-1:0]];
      tbl_bits_rd_q <= tbl_bits_mem[sym_q[SYM_AW-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {3'b000, out_dist_q, out_bits_q, out_len_q, out_sym_q};

  `HCTB_ASSERT_IMPL(a_next_bound, state_q == ST_M_WR, next_q < NEXT_W'(NODES), "node index past end of node store")
  `HCTB_ASSERT_IMPL(a_leaf_bound, state_q == ST_M_PICK, li_q <= n_q, "leaf queue overrun")
  `HCTB_ASSERT_IMPL(a_empty_clean, out_valid_q && out_stat_q == STAT_EMPTY, out_len_q == '0 && out_dist_q == '0, "empty build result not clean")
  `HCTB_ASSERT_NEXT(a_count_silent, s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_COUNT, state_q == ST_CNT_RD || state_q == ST_IDLE, "count item left count path")

endmodule

// File: tb/sv/huffman_code_table_builder_unit_tb.sv
// Self-checking testbench for the Huffman code table builder unit.
module huffman_code_table_builder_unit_tb;
  import hctb_pkg::*;

  localparam int unsigned NSYM        = ALPHABET_DEF;
  localparam int unsigned NODE_CNT    = 2 * NSYM - 1;
  localparam int unsigned ITEM_GOAL   = 1700;
  localparam longint     CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_WAIT  = 20;

  // one result transfer, fields as on the master side
  typedef struct {
    logic [1:0]  status;
    logic [6:0]  sym;
    logic [5:0]  len;
    logic [31:0] bits;
    logic [7:0]  distinct;
  } code_result_t;

  // one input item; fixed marks a row with a typed-in expectation
  typedef struct {
    logic [1:0]   mode;
    logic [7:0]   sym;
    bit           fixed;
    code_result_t want;
  } item_t;

  // directed row: mode, symbol, fixed, status, symbol_out, length, bits, distinct
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  sym;
    logic        fixed;
    logic [1:0]  status;
    logic [6:0]  so;
    logic [5:0]  len;
    logic [31:0] bits;
    logic [7:0]  distinct;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // nothing built after reset: every lookup is absent
    '{MODE_LOOKUP, 8'd0,   1'b1, STAT_ABSENT, 7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_LOOKUP, 8'd255, 1'b1, STAT_ABSENT, 7'd127, 6'd0, 32'd0, 8'd0},
    // empty input
    '{MODE_BUILD,  8'd0,   1'b1, STAT_EMPTY,  7'd0,   6'd0, 32'd0, 8'd0},
    // unused mode: no result
    '{MODE_NONE,   8'd5,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    // single symbol: zero-length code
    '{MODE_COUNT,  8'd127, 1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_COUNT,  8'd200, 1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_BUILD,  8'd0,   1'b1, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd1},
    '{MODE_LOOKUP, 8'd127, 1'b1, STAT_OK,     7'd127, 6'd0, 32'd0, 8'd0},
    '{MODE_LOOKUP, 8'd128, 1'b1, STAT_ABSENT, 7'd0,   6'd0, 32'd0, 8'd0},
    // counts were cleared by the build
    '{MODE_BUILD,  8'd0,   1'b1, STAT_EMPTY,  7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_LOOKUP, 8'd127, 1'b1, STAT_ABSENT, 7'd127, 6'd0, 32'd0, 8'd0},
    // three symbols, two of them tied
    '{MODE_COUNT,  8'd0,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_COUNT,  8'd0,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_COUNT,  8'd1,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_COUNT,  8'd2,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_COUNT,  8'd255, 1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_BUILD,  8'd0,   1'b1, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd3},
    '{MODE_LOOKUP, 8'd0,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_LOOKUP, 8'd1,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_LOOKUP, 8'd2,   1'b0, STAT_OK,     7'd0,   6'd0, 32'd0, 8'd0},
    '{MODE_LOOKUP, 8'd3,   1'b1, STAT_ABSENT, 7'd3,   6'd0, 32'd0, 8'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  huffman_code_table_builder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  logic [31:0] tally [NSYM];
  bit          code_ok [NSYM];
  int          code_len [NSYM];
  logic [63:0] code_path [NSYM];

  item_t        stim_q [$];
  item_t        sent_q [$];
  code_result_t code_q [$];
  int           fail_cnt;
  longint       cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // merge the two lightest nodes until one is left, then settle the codes
  function automatic code_result_t build_codes();
    code_result_t r;
    int          order [NSYM];
    longint      wt [NODE_CNT];
    int          kid0 [NODE_CNT];
    int          kid1 [NODE_CNT];
    int          dep [NODE_CNT];
    logic [63:0] pth [NODE_CNT];
    int          n, li, mi, nx, a, b, j, s;
    longint      w;
    bit          too_long;
    r = '{STAT_OK, 7'd0, 6'd0, 32'd0, 8'd0};
    n = 0;
    too_long = 1'b0;
    for (int i = 0; i < NSYM; i++) if (tally[i] != 0) begin
      order[n] = i;
      n++;
    end
    // stable sort by count
    for (int i = 1; i < n; i++) begin
      s = order[i];
      j = i;
      while (j > 0 && tally[order[j-1]] > tally[s]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = s;
    end
    for (int i = 0; i < NSYM; i++) code_ok[i] = 1'b0;
    if (n == 0) begin
      r.status = STAT_EMPTY;
      return r;
    end
    for (int i = 0; i < n; i++) wt[i] = tally[order[i]];
    li = 0;
    mi = n;
    nx = n;
    while ((n - li) + (nx - mi) > 1) begin
      for (int t = 0; t < 2; t++) begin
        // leaves win ties over merged nodes
        if (li < n && (mi >= nx || wt[li] <= wt[mi])) begin
          a = li;
          li++;
        end else begin
          a = mi;
          mi++;
        end
        if (t == 0) b = a;
      end
      w = wt[b] + wt[a];
      wt[nx] = (w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : w;
      kid0[nx] = b;
      kid1[nx] = a;
      nx++;
    end
    dep[nx-1] = 0;
    pth[nx-1] = '0;
    for (int k = nx - 1; k >= n; k--) begin
      dep[kid0[k]] = dep[k] + 1;
      dep[kid1[k]] = dep[k] + 1;
      pth[kid0[k]] = pth[k] << 1;
      pth[kid1[k]] = (pth[k] << 1) | 64'd1;
    end
    for (int i = 0; i < n; i++) begin
      code_path[order[i]] = pth[i];
      code_len[order[i]]  = dep[i];
      code_ok[order[i]]   = 1'b1;
      if (dep[i] > MAX_CODE_LEN_DEF) too_long = 1'b1;
    end
    for (int i = 0; i < NSYM; i++) tally[i] = '0;
    r.status   = too_long ? STAT_TOO_LONG : STAT_OK;
    r.distinct = n[7:0];
    return r;
  endfunction

  // apply one accepted item to the predictor; returns 1 when it yields a result
  function automatic bit predict_item(input item_t it, output code_result_t r);
    r = '{STAT_OK, it.sym[6:0], 6'd0, 32'd0, 8'd0};
    case (it.mode)
      MODE_COUNT: begin
        if (it.sym < NSYM && tally[it.sym] != 32'hFFFF_FFFF) tally[it.sym]++;
        return 1'b0;
      end
      MODE_BUILD: begin
        r = build_codes();
        return 1'b1;
      end
      MODE_LOOKUP: begin
        if (it.sym >= NSYM || !code_ok[it.sym]) r.status = STAT_ABSENT;
        else if (code_len[it.sym] > MAX_CODE_LEN_DEF) r.status = STAT_TOO_LONG;
        else begin
          r.len  = code_len[it.sym][5:0];
          r.bits = code_path[it.sym][31:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t mk_item(input logic [1:0] mode, input logic [7:0] sym);
    item_t it;
    it.mode  = mode;
    it.sym   = sym;
    it.fixed = 1'b0;
    it.want  = '{STAT_OK, 7'd0, 6'd0, 32'd0, 8'd0};
    return it;
  endfunction

  // stimulus: directed table, then count/build/lookup phases
  initial begin
    item_t it;
    logic [7:0] syms [$];
    int    pool_n, cnt_n, wide_left;
    for (int i = 0; i < NSYM; i++) begin
      tally[i]     = '0;
      code_ok[i]   = 1'b0;
      code_len[i]  = 0;
      code_path[i] = '0;
    end
    foreach (DIRECTED[r]) begin
      it = mk_item(DIRECTED[r].mode, DIRECTED[r].sym);
      it.fixed = DIRECTED[r].fixed;
      it.want  = '{DIRECTED[r].status, DIRECTED[r].so, DIRECTED[r].len,
                   DIRECTED[r].bits, DIRECTED[r].distinct};
      stim_q.push_back(it);
    end
    wide_left = 2;
    while (stim_q.size() < ITEM_GOAL) begin
      syms.delete();
      if (wide_left > 0 && $urandom_range(0, 9) == 0) begin
        // nearly every symbol present: the slow, deep build
        wide_left--;
        for (int i = 0; i < NSYM; i++) syms.push_back(i[7:0]);
        cnt_n = $urandom_range(250, 350);
      end else begin
        pool_n = $urandom_range(1, 12);
        for (int i = 0; i < pool_n; i++) syms.push_back(8'($urandom_range(0, NSYM - 1)));
        cnt_n = $urandom_range(3, 40);
      end
      for (int i = 0; i < cnt_n; i++) begin
        case ($urandom_range(0, 19))
          0:       stim_q.push_back(mk_item(MODE_COUNT, 8'($urandom_range(128, 255))));
          1:       stim_q.push_back(mk_item(MODE_NONE, 8'($urandom_range(0, 255))));
          2:       stim_q.push_back(mk_item(MODE_COUNT, 8'($urandom_range(0, 255))));
          default: stim_q.push_back(mk_item(MODE_COUNT, syms[$urandom_range(0, syms.size()-1)]));
        endcase
      end
      if ($urandom_range(0, 7) != 0)
        stim_q.push_back(mk_item(MODE_BUILD, 8'($urandom_range(0, 255))));
      // an occasional back-to-back build sees empty counts
      if ($urandom_range(0, 15) == 0) stim_q.push_back(mk_item(MODE_BUILD, 8'd0));
      for (int i = $urandom_range(0, 8); i > 0; i--) begin
        if ($urandom_range(0, 3) == 0)
          stim_q.push_back(mk_item(MODE_LOOKUP, 8'($urandom_range(0, 255))));
        else
          stim_q.push_back(mk_item(MODE_LOOKUP, syms[$urandom_range(0, syms.size()-1)]));
      end
    end
  end

  // slave side driver; items 600..999 go without gaps
  initial begin
    int idx;
    bit gap;
    idx           = 0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) idx++;
      if (idx >= stim_q.size()) begin
        s_axis_tvalid <= 1'b0;
        break;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        gap = !(idx >= 600 && idx < 1000) && ($urandom_range(0, 99) < 17);
        if (gap) s_axis_tvalid <= 1'b0;
        else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= stim_q[idx].sym;
          s_axis_tuser  <= stim_q[idx].mode;
          sent_q.push_back(stim_q[idx]);
        end
      end
    end
    while (sent_q.size() != 0 || code_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (code_q.size() == 0 && fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // master side stall; a long window keeps it always ready
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cycle_cnt > 20000 && cycle_cnt < 60000) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 99) >= 17);
    end
  end

  // predict on each input transfer, check each output transfer
  initial begin
    code_result_t got, want;
    item_t it;
    fail_cnt  = 0;
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (rst_ni && s_axis_tvalid && s_axis_tready) begin
        it = sent_q.pop_front();
        if (predict_item(it, want)) code_q.push_back(it.fixed ? it.want : want);
      end
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[12:7],
                m_axis_tdata[44:13], m_axis_tdata[52:45]};
        if (code_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_cnt++;
        end else begin
          want = code_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
          end
          if (got.sym !== want.sym) begin
            $error("symbol_out: expected %0d, got %0d", want.sym, got.sym);
            fail_cnt++;
          end
          if (got.len !== want.len) begin
            $error("code_length: expected %0d, got %0d", want.len, got.len);
            fail_cnt++;
          end
          if (got.bits !== want.bits) begin
            $error("code_bits: expected %h, got %h", want.bits, got.bits);
            fail_cnt++;
          end
          if (got.distinct !== want.distinct) begin
            $error("distinct_symbols: expected %0d, got %0d", want.distinct, got.distinct);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule
